@@ src/bpei_pkg.sv @@
package bpei_pkg;

    localparam int MAX_POINTS     = 64;
    localparam int MAX_SAMPLES    = 64;
    localparam int GAIN_FRAC_BITS = 16;

    localparam int TIME_W    = 32;
    localparam int GAIN_W    = 18;
    localparam int CNT_W     = 7;
    localparam int REQ_W     = 2;
    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int ACC_W     = TIME_W + $clog2(MAX_SAMPLES) + 2;
    localparam int PROD_W    = GAIN_W + TIME_W;
    localparam int DIV_CNT_W = $clog2(GAIN_W + 1);

    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(64'(1) << GAIN_FRAC_BITS);
    localparam logic [TIME_W-1:0] END_TIME   = TIME_W'(1000000000);

    typedef logic [REQ_W-1:0] t_req;

    localparam t_req REQ_EVAL   = 2'd0;
    localparam t_req REQ_INSERT = 2'd1;
    localparam t_req REQ_FLAT   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS,
        S_FLAT,
        S_EV_TIME,
        S_EV_CMP,
        S_EV_SEL,
        S_EV_DIFF,
        S_EV_MUL,
        S_EV_SUM,
        S_EV_DIV,
        S_EV_OUT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] tick;
        logic [GAIN_W-1:0] gain;
    } t_point;

    typedef struct packed {
        t_point pt;
        logic   ge;
        logic   sel_lo;
    } t_left_info;

    typedef struct packed {
        logic le;
        logic valid;
        logic is_last;
    } t_right_info;

    typedef struct packed {
        logic              ins_en;
        logic              flat_en;
        logic              cmp_en;
        logic [TIME_W-1:0] ins_time;
        logic [GAIN_W-1:0] ins_gain;
        logic [TIME_W-1:0] qt;
    } t_cell_ctrl;

    typedef struct packed {
        logic [TIME_W-1:0] lo_tick;
        logic [GAIN_W-1:0] lo_gain;
        logic [TIME_W-1:0] hi_tick;
        logic [GAIN_W-1:0] hi_gain;
        logic              last_lt;
        logic              spot;
    } t_cell_pick;

endpackage

@@ src/breakpoint_envelope_interpolator_core.sv @@
// Insert and flatten words give their one result word through the output register, and
// the next word can be taken once the sequencer is back in idle. An evaluate word gives
// one result per sample; a sample skips the multiply and divide states when it falls
// outside the table or on a zero-length segment, and otherwise waits for the 18-step
// restoring divider. A stalled result word holds the sequencer for as long as the stall
// lasts. One request is worked on at a time. Reset is synchronous and active low; it
// restores the two-point unity table and a zero time offset at once, with no clearing pass.
module breakpoint_envelope_interpolator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [bpei_pkg::TIME_W-1:0]  i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  bpei_pkg::t_req               i_req_type,
    input  logic [bpei_pkg::TIME_W-1:0]  i_time_point,
    input  logic [bpei_pkg::TIME_W-1:0]  i_time_step,
    input  logic [bpei_pkg::CNT_W-1:0]   i_sample_count,
    input  logic [bpei_pkg::GAIN_W-1:0]  i_point_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bpei_pkg::GAIN_W-1:0]  o_gain_out,
    output logic [bpei_pkg::IDX_W-1:0]   o_insert_index,
    output logic                         o_table_full,
    output logic                         o_last_of_run
);
    import bpei_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [TIME_W-1:0] r_offset;
    logic [TIME_W-1:0] r_tpt;
    logic [TIME_W-1:0] r_step;
    logic [GAIN_W-1:0] r_val;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_k;
    logic [ACC_W-1:0]  r_acc;
    logic [TIME_W-1:0] r_qt;
    logic              r_unity;
    logic [TIME_W-1:0] r_tp;
    logic [TIME_W-1:0] r_tn;
    logic [GAIN_W-1:0] r_gp;
    logic [GAIN_W-1:0] r_gn;
    logic [TIME_W-1:0] r_dn;
    logic [TIME_W-1:0] r_to;
    logic [PROD_W-1:0] r_p0;
    logic [PROD_W-1:0] r_p1;
    logic [GAIN_W-1:0] r_result;

    logic              r_out_valid;
    logic [GAIN_W-1:0] r_out_gain;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_full;
    logic              r_out_last;

    logic              w_out_free;
    logic              w_out_load;
    logic [GAIN_W-1:0] w_out_gain;
    logic [IDX_W-1:0]  w_out_idx;
    logic              w_out_full;
    logic              w_out_last;
    logic              w_div_start;
    logic              w_div_done;
    logic [GAIN_W-1:0] w_div_quo;
    logic [PROD_W-1:0] w_num;
    logic [CNT_W-1:0]  w_cnt_sat;
    logic [TIME_W-1:0] w_qt;
    logic              w_full;
    logic              w_last_sample;

    t_cell_ctrl        w_ctrl;
    t_left_info        w_l2r [MAX_POINTS+1];
    t_right_info       w_r2l [MAX_POINTS+1];
    t_cell_pick        w_pick [MAX_POINTS];
    logic [MAX_POINTS-1:0] w_valid;

    logic [TIME_W-1:0] w_lo_tick;
    logic [GAIN_W-1:0] w_lo_gain;
    logic [TIME_W-1:0] w_hi_tick;
    logic [GAIN_W-1:0] w_hi_gain;
    logic              w_last_lt;
    logic [IDX_W-1:0]  w_ins_idx;

    assign w_l2r[0].pt     = '0;
    assign w_l2r[0].ge     = 1'b1;
    assign w_l2r[0].sel_lo = 1'b0;
    assign w_r2l[MAX_POINTS] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++) begin : g_cell
            bpei_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_is_first   (g == 0),
                .i_init_valid (g < 2),
                .i_init_tick  ((g == 1) ? END_TIME : '0),
                .i_left       (w_l2r[g]),
                .i_right      (w_r2l[g+1]),
                .o_to_right   (w_l2r[g+1]),
                .o_to_left    (w_r2l[g]),
                .o_pick       (w_pick[g])
            );
            assign w_valid[g] = w_r2l[g].valid;
        end
    endgenerate

    assign w_full = w_l2r[MAX_POINTS].pt.valid;

    always_comb begin
        w_lo_tick = '0;
        w_lo_gain = '0;
        w_hi_tick = '0;
        w_hi_gain = '0;
        w_last_lt = 1'b0;
        w_ins_idx = '0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            w_lo_tick = w_lo_tick | w_pick[i].lo_tick;
            w_lo_gain = w_lo_gain | w_pick[i].lo_gain;
            w_hi_tick = w_hi_tick | w_pick[i].hi_tick;
            w_hi_gain = w_hi_gain | w_pick[i].hi_gain;
            w_last_lt = w_last_lt | w_pick[i].last_lt;
            if (w_pick[i].spot) begin
                w_ins_idx = w_ins_idx | IDX_W'(i);
            end
        end
    end

    assign w_cnt_sat = (i_sample_count > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                               : i_sample_count;
    assign w_qt = (|r_acc[ACC_W-2:TIME_W]) ? '1 : r_acc[TIME_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_sample = (CNT_W'(r_k + 1'b1) == r_cnt);
    assign w_num = r_p0 + r_p1;

    bpei_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_dn + r_to),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_stall      = 1'b1;
        w_ctrl.ins_en   = 1'b0;
        w_ctrl.flat_en  = 1'b0;
        w_ctrl.cmp_en   = 1'b0;
        w_ctrl.ins_time = r_tpt;
        w_ctrl.ins_gain = r_val;
        w_ctrl.qt       = r_qt;
        w_out_load      = 1'b0;
        w_out_gain      = '0;
        w_out_idx       = '0;
        w_out_full      = 1'b0;
        w_out_last      = 1'b0;
        w_div_start     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_req_type)
                        REQ_EVAL: begin
                            if (w_cnt_sat != '0) begin
                                n_state = S_EV_TIME;
                            end
                        end
                        REQ_INSERT: n_state = S_INS;
                        REQ_FLAT:   n_state = S_FLAT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (w_out_free) begin
                    w_ctrl.ins_en = !w_full;
                    w_out_load    = 1'b1;
                    w_out_idx     = w_full ? '0 : w_ins_idx;
                    w_out_full    = w_full;
                    w_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_FLAT: begin
                if (w_out_free) begin
                    w_ctrl.flat_en = 1'b1;
                    w_out_load     = 1'b1;
                    w_out_last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_EV_TIME: n_state = S_EV_CMP;
            S_EV_CMP: begin
                w_ctrl.cmp_en = 1'b1;
                n_state       = S_EV_SEL;
            end
            S_EV_SEL: n_state = S_EV_DIFF;
            S_EV_DIFF: begin
                if (r_unity || (r_tn <= r_tp)) begin
                    n_state = S_EV_OUT;
                end else begin
                    n_state = S_EV_MUL;
                end
            end
            S_EV_MUL: n_state = S_EV_SUM;
            S_EV_SUM: begin
                w_div_start = 1'b1;
                n_state     = S_EV_DIV;
            end
            S_EV_DIV: begin
                if (w_div_done) begin
                    n_state = S_EV_OUT;
                end
            end
            S_EV_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_gain = r_result;
                    w_out_last = w_last_sample;
                    n_state    = w_last_sample ? S_IDLE : S_EV_TIME;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_wr_en) begin
            r_offset <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_tpt  <= i_time_point;
                    r_step <= i_time_step;
                    r_val  <= i_point_value;
                    r_cnt  <= w_cnt_sat;
                    r_k    <= '0;
                    r_acc  <= ACC_W'(i_time_point) - ACC_W'(r_offset);
                end
            end
            S_EV_TIME: begin
                r_qt    <= w_qt;
                r_unity <= r_acc[ACC_W-1];
            end
            S_EV_SEL: begin
                r_tp    <= w_lo_tick;
                r_gp    <= w_lo_gain;
                r_tn    <= w_hi_tick;
                r_gn    <= w_hi_gain;
                r_unity <= r_unity || !w_r2l[0].le || w_last_lt;
            end
            S_EV_DIFF: begin
                r_dn <= r_tn - r_qt;
                r_to <= r_qt - r_tp;
                if (r_unity) begin
                    r_result <= UNITY_GAIN;
                end else if (r_tn <= r_tp) begin
                    r_result <= r_gn;
                end
            end
            S_EV_MUL: begin
                r_p0 <= PROD_W'(r_gp) * PROD_W'(r_dn);
                r_p1 <= PROD_W'(r_gn) * PROD_W'(r_to);
            end
            S_EV_DIV: begin
                if (w_div_done) begin
                    r_result <= w_div_quo;
                end
            end
            S_EV_OUT: begin
                if (w_out_free) begin
                    r_k   <= CNT_W'(r_k + 1'b1);
                    r_acc <= r_acc + ACC_W'(r_step);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_gain <= w_out_gain;
            r_out_idx  <= w_out_idx;
            r_out_full <= w_out_full;
            r_out_last <= w_out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_gain_out     = r_out_gain;
    assign o_insert_index = r_out_idx;
    assign o_table_full   = r_out_full;
    assign o_last_of_run  = r_out_last;

    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + MAX_POINTS'(1))) == '0))
        else $error("Point table valid bits are not a contiguous prefix.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && w_out_free && !w_full) |=>
        ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("An accepted insert did not add exactly one point.");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && w_full) |=> $stable(w_valid))
        else $error("A refused insert changed the table.");

    a_flat_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLAT && w_out_free) |=> (w_valid == MAX_POINTS'(3)))
        else $error("Flatten did not leave exactly two points.");

endmodule

@@ src/bpei_cell.sv @@
module bpei_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpei_pkg::t_cell_ctrl         i_ctrl,
    input  logic                         i_is_first,
    input  logic                         i_init_valid,
    input  logic [bpei_pkg::TIME_W-1:0]  i_init_tick,
    input  bpei_pkg::t_left_info         i_left,
    input  bpei_pkg::t_right_info        i_right,
    output bpei_pkg::t_left_info         o_to_right,
    output bpei_pkg::t_right_info        o_to_left,
    output bpei_pkg::t_cell_pick         o_pick
);
    import bpei_pkg::*;

    t_point r_pt;
    t_point n_pt;
    logic   r_le;
    logic   r_lt;
    logic   w_ge;
    logic   w_is_last;
    logic   w_sel_lo;
    logic   w_sel_hi;

    assign w_ge      = r_pt.valid && (i_ctrl.ins_time >= r_pt.tick);
    assign w_is_last = r_pt.valid && !i_right.valid;

    // The lower point of the segment is the last point at or below the query time,
    // but never the final point of the table unless it is the only point.
    assign w_sel_lo = r_le && ((!i_right.le && !w_is_last) ||
                               (i_right.is_last && i_right.le) ||
                               (i_is_first && w_is_last));
    assign w_sel_hi = i_left.sel_lo || (i_is_first && w_is_last);

    always_comb begin
        n_pt = r_pt;
        if (i_ctrl.flat_en) begin
            n_pt.valid = i_init_valid;
            n_pt.tick  = i_init_tick;
            n_pt.gain  = i_ctrl.ins_gain;
        end else if (i_ctrl.ins_en && !w_ge) begin
            if (i_left.ge) begin
                n_pt.valid = 1'b1;
                n_pt.tick  = i_ctrl.ins_time;
                n_pt.gain  = i_ctrl.ins_gain;
            end else begin
                n_pt = i_left.pt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt.valid <= i_init_valid;
            r_pt.tick  <= i_init_tick;
            r_pt.gain  <= UNITY_GAIN;
            r_le       <= 1'b0;
            r_lt       <= 1'b0;
        end else begin
            r_pt <= n_pt;
            if (i_ctrl.cmp_en) begin
                r_le <= r_pt.valid && (r_pt.tick <= i_ctrl.qt);
                r_lt <= r_pt.valid && (r_pt.tick < i_ctrl.qt);
            end
        end
    end

    assign o_to_right.pt     = r_pt;
    assign o_to_right.ge     = w_ge;
    assign o_to_right.sel_lo = w_sel_lo && !w_is_last;

    assign o_to_left.le      = r_le;
    assign o_to_left.valid   = r_pt.valid;
    assign o_to_left.is_last = w_is_last;

    assign o_pick.lo_tick = w_sel_lo ? r_pt.tick : '0;
    assign o_pick.lo_gain = w_sel_lo ? r_pt.gain : '0;
    assign o_pick.hi_tick = w_sel_hi ? r_pt.tick : '0;
    assign o_pick.hi_gain = w_sel_hi ? r_pt.gain : '0;
    assign o_pick.last_lt = w_is_last && r_lt;
    assign o_pick.spot    = !w_ge && i_left.ge;

endmodule

@@ src/bpei_div.sv @@
module bpei_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bpei_pkg::PROD_W-1:0]  i_num,
    input  logic [bpei_pkg::TIME_W-1:0]  i_den,
    output logic                         o_done,
    output logic [bpei_pkg::GAIN_W-1:0]  o_quo
);
    import bpei_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]    r_rem;
    logic [GAIN_W-1:0]    r_low;
    logic [GAIN_W-1:0]    r_quo;
    logic [TIME_W-1:0]    r_den;
    logic [TIME_W:0]      w_sh;
    logic [TIME_W:0]      w_diff;
    logic                 w_take;

    // The numerator is a weighted mean times the denominator, so the quotient fits
    // the gain width and the upper part of the numerator is already below the divisor.
    assign w_sh   = {r_rem, r_low[GAIN_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_take = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(GAIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_W-1:GAIN_W];
            r_low <= i_num[GAIN_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_take ? w_diff[TIME_W-1:0] : w_sh[TIME_W-1:0];
            r_low <= {r_low[GAIN_W-2:0], 1'b0};
            r_quo <= {r_quo[GAIN_W-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
